FILE: rtl/life_automaton_generation_step_unit_macros.svh
// Assertion macros for the life automaton generation step unit.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef LIFE_AUTOMATON_GENERATION_STEP_UNIT_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_STEP_UNIT_MACROS_SVH

// Same-cycle implication
`define LAGS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lags assertion failed");

// Next-cycle implication
`define LAGS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lags assertion failed");

`endif

FILE: rtl/lags_pkg.sv
// Shared types, constants and the cell update rule for the life automaton unit.
// No dependencies; imported by lags_cell_chain, the top level and the testbench.
package lags_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int AGE_W      = 3;
   localparam int COUNT_W    = 4;
   localparam int GEN_W      = 16;

   localparam int AGE_LIMIT   = 8;
   localparam int BIRTH_COUNT = 3;
   localparam int SURVIVE_MIN = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_WRAP  = 2'd2,
      CSR_AGING = 2'd3
   } csr_type;

   // Center age and live-neighbor count of the 3x3 window
   typedef struct packed {
      logic [AGE_W-1:0]   center;
      logic [COUNT_W-1:0] count;
   } window_type;

   // B3/S23 with optional aging
   function automatic logic [AGE_W-1:0] next_age(input logic [AGE_W-1:0] age,
                                                 input logic [COUNT_W-1:0] count,
                                                 input logic aging);
      logic [AGE_W:0] older;
      logic           survive;
      older   = {1'b0, age} + (AGE_W+1)'(1);
      survive = (count == COUNT_W'(SURVIVE_MIN)) || (count == COUNT_W'(BIRTH_COUNT));
      if (age != '0) begin
         if (!survive) return '0;
         if (!aging) return age;
         if (older >= (AGE_W+1)'(AGE_LIMIT)) return '0;
         return older[AGE_W-1:0];
      end
      return (count == COUNT_W'(BIRTH_COUNT)) ? AGE_W'(1) : '0;
   endfunction

endpackage

FILE: rtl/life_automaton_generation_step_unit.sv
// Life automaton (B3/S23, optional aging) over a grid memory with a cell chain.
// Step: the padded grid streams once through the read port.
// Write, other: the all-dead scan streams the region once (a read first looks up its cell).
// One item at a time; a new item is taken while the previous result waits.
// Reset: a clearing pass writes every grid cell to zero, no items taken; csr writes taken.
`include "life_automaton_generation_step_unit_macros.svh"
module life_automaton_generation_step_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // operation[1:0], row[7:2], col[13:8], age[16:14], zero fill
   input  logic [lags_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cell_age[2:0], all_dead[3], generation[19:4], zero fill
   output logic [lags_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [lags_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lags_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lags_pkg::*;

   localparam int ROW_LEN = MAX_COLS + 2;
   localparam int CELLS   = MAX_ROWS * MAX_COLS;
   localparam int AW      = $clog2(CELLS);
   localparam int RW      = $clog2(MAX_ROWS);
   localparam int CLW     = $clog2(MAX_COLS);
   localparam int PRW     = $clog2(MAX_ROWS + 2);
   localparam int PCW     = $clog2(MAX_COLS + 2);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_STEP   = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type            state_ff;
   logic [AW-1:0]        clr_ff;
   logic [GEN_W-1:0]     gen_ff;
   logic [6:0]           rows_ff, cols_ff;
   logic                 wrap_ff, aging_ff;
   logic [PRW-1:0]       pr_ff;
   logic [PCW-1:0]       pc_ff;
   logic                 issue_ff, tag_v_ff, wr_v_ff, live_ff, in_store_ff;
   logic                 tag_zero_ff, tag_buf_ff;
   logic [PRW-1:0]       tag_pr_ff;
   logic [PCW-1:0]       tag_pc_ff;
   logic [CLW-1:0]       tag_sc_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic [AGE_W-1:0]     wr_data_ff;
   logic [AGE_W-1:0]     cell_age_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [AGE_W-1:0]     mem_rd_ff, buf_rd_ff;

   logic [AGE_W-1:0]     grid_mem [CELLS];
   logic [AGE_W-1:0]     row_mem [MAX_COLS];

   logic [1:0]           req_op;
   logic [5:0]           req_row, req_col;
   logic [AGE_W-1:0]     req_age;
   logic                 req_xfer, in_store;
   logic [AW-1:0]        req_addr;
   logic [PRW-1:0]       nr;
   logic [PCW-1:0]       nc;
   logic [RW-1:0]        src_row;
   logic [CLW-1:0]       src_col;
   logic                 src_zero, src_buf;
   logic [AW-1:0]        stream_addr;
   logic                 pc_last, pr_last;
   logic [AGE_W-1:0]     stream_data;
   logic                 shift_en, center_valid, buf_we;
   window_type           window;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [AGE_W-1:0]     mem_wdata;

   // Unpack request fields
   assign req_op   = req_tdata[1:0];
   assign req_row  = req_tdata[7:2];
   assign req_col  = req_tdata[13:8];
   assign req_age  = req_tdata[16:14];
   assign req_xfer = req_tvalid && req_tready;
   assign in_store = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
   assign req_addr = AW'(32'(req_row) * MAX_COLS + 32'(req_col));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Clamp the region size into 1..MAX
   always_comb begin
      if (rows_ff == '0) nr = PRW'(1);
      else if (32'(rows_ff) > MAX_ROWS) nr = PRW'(MAX_ROWS);
      else nr = PRW'(rows_ff);
      if (cols_ff == '0) nc = PCW'(1);
      else if (32'(cols_ff) > MAX_COLS) nc = PCW'(MAX_COLS);
      else nc = PCW'(cols_ff);
   end

   // Map the stream position to a grid cell, a padding zero or the saved top row
   always_comb begin
      src_zero = 1'b0;
      src_buf  = 1'b0;
      src_row  = RW'(pr_ff);
      src_col  = CLW'(pc_ff);
      if (state_ff == ST_STEP) begin
         if (pr_ff == '0) begin
            src_row  = RW'(nr - PRW'(1));
            src_zero = !wrap_ff;
         end else if (pr_ff <= nr) begin
            src_row = RW'(pr_ff - PRW'(1));
         end else begin
            src_row  = '0;
            src_buf  = wrap_ff;
            src_zero = !wrap_ff;
         end
         if (pc_ff == '0) begin
            src_col = CLW'(nc - PCW'(1));
            if (!wrap_ff) src_zero = 1'b1;
         end else if (pc_ff <= nc) begin
            src_col = CLW'(pc_ff - PCW'(1));
         end else if (pc_ff == nc + PCW'(1)) begin
            src_col = '0;
            if (!wrap_ff) src_zero = 1'b1;
         end else begin
            src_col  = '0;
            src_zero = 1'b1;
         end
      end
   end

   assign stream_addr = AW'(32'(src_row) * MAX_COLS + 32'(src_col));

   // Stream limits: padded frame for a step, bare region for a scan
   always_comb begin
      if (state_ff == ST_STEP) begin
         pc_last = (pc_ff == PCW'(ROW_LEN - 1));
         pr_last = (pr_ff == nr + PRW'(1));
      end else begin
         pc_last = (pc_ff == nc - PCW'(1));
         pr_last = (pr_ff == nr - PRW'(1));
      end
   end

   assign stream_data = tag_zero_ff ? '0 : (tag_buf_ff ? buf_rd_ff : mem_rd_ff);
   assign shift_en    = tag_v_ff && (state_ff == ST_STEP);
   assign center_valid = shift_en && (tag_pr_ff >= PRW'(2)) && (tag_pc_ff >= PCW'(2))
                         && (tag_pc_ff <= nc + PCW'(1));
   assign buf_we = shift_en && (tag_pr_ff == PRW'(1)) && (tag_pc_ff >= PCW'(1))
                   && (tag_pc_ff <= nc);

   lags_cell_chain #(
      .ROW_LEN (ROW_LEN)
   ) u_chain (
      .clock    (clock),
      .shift_en (shift_en),
      .cell_in  (stream_data),
      .window   (window)
   );

   // Select the single write port and the read address
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = wr_data_ff;
      mem_raddr = stream_addr;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            mem_we    = req_xfer && (req_op == OP_WRITE) && in_store;
            mem_waddr = req_addr;
            mem_wdata = req_age;
            mem_raddr = req_addr;
         end
         ST_STEP: begin
            mem_we = wr_v_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Grid memory and saved copy of the top row
   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= grid_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (buf_we) row_mem[tag_sc_ff] <= mem_rd_ff;
      buf_rd_ff <= row_mem[src_col];
   end

   // Stream tags and write-back stage
   always_ff @(posedge clock) begin
      tag_zero_ff <= src_zero;
      tag_buf_ff  <= src_buf;
      tag_pr_ff   <= pr_ff;
      tag_pc_ff   <= pc_ff;
      tag_sc_ff   <= src_col;
      wr_addr_ff  <= AW'(32'(tag_pr_ff - PRW'(2)) * MAX_COLS + 32'(tag_pc_ff - PCW'(2)));
      wr_data_ff  <= next_age(window.center, window.count, aging_ff);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 7'd64;
         cols_ff  <= 7'd64;
         wrap_ff  <= 1'b1;
         aging_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_wdata;
            CSR_COLS:  cols_ff  <= csr_wdata;
            CSR_WRAP:  wrap_ff  <= csr_wdata[0];
            CSR_AGING: aging_ff <= csr_wdata[0];
            default:   rows_ff  <= rows_ff;
         endcase
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         gen_ff        <= '0;
         issue_ff      <= 1'b0;
         tag_v_ff      <= 1'b0;
         wr_v_ff       <= 1'b0;
         live_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         tag_v_ff <= issue_ff;
         wr_v_ff  <= center_valid;
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(CELLS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  cell_age_ff <= '0;
                  live_ff     <= 1'b0;
                  pr_ff       <= '0;
                  pc_ff       <= '0;
                  in_store_ff <= in_store;
                  case (req_op)
                     OP_STEP: begin
                        gen_ff   <= gen_ff + GEN_W'(1);
                        issue_ff <= 1'b1;
                        state_ff <= ST_STEP;
                     end
                     OP_READ: begin
                        state_ff <= ST_LOOKUP;
                     end
                     default: begin
                        issue_ff <= 1'b1;
                        state_ff <= ST_SCAN;
                     end
                  endcase
               end
            end
            ST_LOOKUP: begin
               cell_age_ff <= in_store_ff ? mem_rd_ff : '0;
               issue_ff    <= 1'b1;
               state_ff    <= ST_SCAN;
            end
            ST_STEP, ST_SCAN: begin
               // advance the stream position
               if (issue_ff) begin
                  pc_ff <= pc_last ? '0 : pc_ff + PCW'(1);
                  if (pc_last) pr_ff <= pr_ff + PRW'(1);
                  if (pc_last && pr_last) issue_ff <= 1'b0;
               end
               if ((state_ff == ST_SCAN) && tag_v_ff && (stream_data != '0)) live_ff <= 1'b1;
               if ((state_ff == ST_STEP) && wr_v_ff && (wr_data_ff != '0)) live_ff <= 1'b1;
               if (!issue_ff && !tag_v_ff && !wr_v_ff) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= {4'b0, gen_ff, !live_ff, cell_age_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Checks
   `LAGS_ASSERT_NOW(a_writeback_in_step, wr_v_ff, state_ff == ST_STEP)
   `LAGS_ASSERT_NOW(a_tag_in_stream, tag_v_ff, (state_ff == ST_STEP) || (state_ff == ST_SCAN))
   `LAGS_ASSERT_NEXT(a_gen_on_step, req_xfer && (req_op == OP_STEP), gen_ff == $past(gen_ff) + GEN_W'(1))

endmodule

FILE: rtl/lags_cell_chain.sv
// Chain of cells holding two padded rows plus two ages of the streamed grid.
// Each cell hands its age to the next on every shift; taps form the 3x3 window.
// Depends on lags_pkg.
module lags_cell_chain #(
   parameter int ROW_LEN = 66
) (
   input  logic                          clock,
   input  logic                          shift_en,
   input  logic [lags_pkg::AGE_W-1:0]    cell_in,
   output lags_pkg::window_type          window
);
   import lags_pkg::*;

   localparam int DEPTH = 2 * ROW_LEN + 2;

   logic [AGE_W-1:0] cell_ff [DEPTH];
   logic [7:0]       live;

   // Shift the chain by one position per transfer of streamed data
   always_ff @(posedge clock) begin
      if (shift_en) begin
         cell_ff[0] <= cell_in;
         for (int k = 1; k < DEPTH; k++) begin
            cell_ff[k] <= cell_ff[k-1];
         end
      end
   end

   // Neighbor taps: top row, middle sides, bottom row with incoming cell
   always_comb begin
      live[0] = |cell_ff[2*ROW_LEN+1];
      live[1] = |cell_ff[2*ROW_LEN];
      live[2] = |cell_ff[2*ROW_LEN-1];
      live[3] = |cell_ff[ROW_LEN+1];
      live[4] = |cell_ff[ROW_LEN-1];
      live[5] = |cell_ff[1];
      live[6] = |cell_ff[0];
      live[7] = |cell_in;
      window.count = '0;
      for (int k = 0; k < 8; k++) begin
         window.count = window.count + COUNT_W'(live[k]);
      end
      window.center = cell_ff[ROW_LEN];
   end

endmodule

FILE: sim/life_automaton_generation_step_unit_tb.sv
// Testbench for life_automaton_generation_step_unit: drives cell writes, reads and
// generation steps and checks every response against an in-bench grid model.
// Depends on lags_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module life_automaton_generation_step_unit_tb;
   import lags_pkg::*;

   localparam int GRID_ROWS  = 64;
   localparam int GRID_COLS  = 64;
   localparam int IDLE_LIMIT = 20000;

   // Fields from the highest bit down: generation, all_dead, cell_age
   typedef struct packed {
      logic [15:0] generation;
      logic        all_dead;
      logic [2:0]  cell_age;
   } life_rsp_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Model state
   logic [2:0]  cell_ages [GRID_ROWS*GRID_COLS];
   logic [2:0]  frozen_ages [GRID_ROWS*GRID_COLS];
   logic [15:0] gen_count;
   logic [6:0]  rows_reg, cols_reg;
   logic        wrap_reg, aging_reg;

   life_rsp_t   pending_rsp [$];
   int          error_count = 0;
   bit          send_gaps = 1'b1;
   bit          drain_stalls = 1'b1;
   int          idle_cycles = 0;

   life_automaton_generation_step_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int clamp_dim(input logic [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return int'(v);
   endfunction

   function automatic bit region_empty();
      int nr, nc;
      nr = clamp_dim(rows_reg);
      nc = clamp_dim(cols_reg);
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            if (cell_ages[r*GRID_COLS + c] != 0) return 1'b0;
      return 1'b1;
   endfunction

   // Run one generation from a frozen copy of the grid
   task automatic advance_generation();
      int nr, nc, live, rr, cc;
      logic [3:0] older;
      logic [2:0] a;
      nr = clamp_dim(rows_reg);
      nc = clamp_dim(cols_reg);
      frozen_ages = cell_ages;
      gen_count++;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr == 0 && dc == 0) continue;
                  rr = r + dr;
                  cc = c + dc;
                  if (wrap_reg) begin
                     rr = (rr + nr) % nr;
                     cc = (cc + nc) % nc;
                  end else if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) begin
                     continue;
                  end
                  if (frozen_ages[rr*GRID_COLS + cc] != 0) live++;
               end
            end
            a = cell_ages[r*GRID_COLS + c];
            if (a != 0) begin
               if (live == SURVIVE_MIN || live == BIRTH_COUNT) begin
                  if (aging_reg) begin
                     older = {1'b0, a} + 4'd1;
                     cell_ages[r*GRID_COLS + c] = (older >= AGE_LIMIT) ? 3'd0 : older[2:0];
                  end
               end else begin
                  cell_ages[r*GRID_COLS + c] = 3'd0;
               end
            end else if (live == BIRTH_COUNT) begin
               cell_ages[r*GRID_COLS + c] = 3'd1;
            end
         end
      end
   endtask

   // Apply one accepted item to the model and queue its response
   task automatic apply_item(input op_type op, input logic [5:0] row, input logic [5:0] col,
                             input logic [2:0] age);
      life_rsp_t exp_rsp;
      exp_rsp.cell_age = '0;
      case (op)
         OP_WRITE: cell_ages[row*GRID_COLS + col] = age;
         OP_READ:  exp_rsp.cell_age = cell_ages[row*GRID_COLS + col];
         OP_STEP:  advance_generation();
         default:  ;
      endcase
      exp_rsp.all_dead   = region_empty();
      exp_rsp.generation = gen_count;
      pending_rsp.push_back(exp_rsp);
   endtask

   // Send one request transfer
   task automatic send_cell_op(input op_type op, input logic [5:0] row = 0,
                               input logic [5:0] col = 0, input logic [2:0] age = 0);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, age, col, row, op};
      do @(posedge clock); while (!req_tready);
      apply_item(op, row, col, age);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [6:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_ROWS:  rows_reg  = value;
         CSR_COLS:  cols_reg  = value;
         CSR_WRAP:  wrap_reg  = value[0];
         CSR_AGING: aging_reg = value[0];
         default:   ;
      endcase
   endtask

   task automatic set_shape(input logic [6:0] nr, input logic [6:0] nc, input bit wrap,
                            input bit aging);
      wait_idle();
      write_csr(CSR_ROWS, nr);
      write_csr(CSR_COLS, nc);
      write_csr(CSR_WRAP, {6'd0, wrap});
      write_csr(CSR_AGING, {6'd0, aging});
   endtask

   // Full-size torus at reset settings: extremes, every operation, wrap at corners
   task automatic test_reset_grid();
      send_cell_op(OP_READ, 6'd63, 6'd63);
      send_cell_op(OP_WRITE, 6'd0, 6'd0, 3'd7);
      send_cell_op(OP_WRITE, 6'd63, 6'd63, 3'd7);
      send_cell_op(OP_WRITE, 6'd0, 6'd63, 3'd5);
      send_cell_op(OP_READ, 6'd0, 6'd0);
      send_cell_op(OP_NONE, 6'd42, 6'd21, 3'd6);
      // corner cells neighbor each other across both edges: birth at (63,0)
      send_cell_op(OP_STEP);
      send_cell_op(OP_READ, 6'd63, 6'd0);
      send_cell_op(OP_READ, 6'd63, 6'd63);
      send_cell_op(OP_STEP);
      send_cell_op(OP_READ, 6'd0, 6'd63);
   endtask

   // Aging on a still block, bounded edges; cells die on reaching the age limit
   task automatic test_aging_block();
      set_shape(7'd6, 7'd6, 1'b0, 1'b1);
      send_cell_op(OP_WRITE, 6'd0, 6'd0, 3'd4);
      send_cell_op(OP_WRITE, 6'd0, 6'd1, 3'd1);
      send_cell_op(OP_WRITE, 6'd1, 6'd0, 3'd1);
      send_cell_op(OP_WRITE, 6'd1, 6'd1, 3'd6);
      send_cell_op(OP_WRITE, 6'd40, 6'd40, 3'd3); // outside the region: untouched
      repeat (4) send_cell_op(OP_STEP);
      send_cell_op(OP_READ, 6'd1, 6'd1);
      send_cell_op(OP_READ, 6'd0, 6'd0);
      send_cell_op(OP_READ, 6'd40, 6'd40);
   endtask

   // Out-of-range sizes: zero acts as one, oversize as the maximum; tiny torus
   task automatic test_tiny_torus();
      set_shape(7'd0, 7'd100, 1'b1, 1'b0);
      send_cell_op(OP_WRITE, 6'd0, 6'd5, 3'd2);
      send_cell_op(OP_WRITE, 6'd0, 6'd6, 3'd2);
      send_cell_op(OP_WRITE, 6'd0, 6'd7, 3'd2);
      send_cell_op(OP_STEP);
      send_cell_op(OP_READ, 6'd0, 6'd6);
      send_cell_op(OP_READ, 6'd0, 6'd5);
      set_shape(7'd3, 7'd1, 1'b1, 1'b1);
      send_cell_op(OP_WRITE, 6'd1, 6'd0, 3'd3);
      send_cell_op(OP_STEP);
      send_cell_op(OP_STEP);
   endtask

   // Seed a region with a random pattern, then step and probe it
   task automatic test_random_colony(input logic [6:0] nr, input logic [6:0] nc,
                                     input bit wrap, input bit aging, input int items);
      int hr, hc, pick;
      set_shape(nr, nc, wrap, aging);
      hr = clamp_dim(nr) - 1;
      hc = clamp_dim(nc) - 1;
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_cell_op(OP_WRITE, 6'($urandom_range(0, hr)), 6'($urandom_range(0, hc)),
                         ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(1, 7)));
         else if (pick < 65)
            send_cell_op(OP_STEP);
         else if (pick < 85)
            send_cell_op(OP_READ, 6'($urandom_range(0, hr)), 6'($urandom_range(0, hc)));
         else if (pick < 95)
            send_cell_op(op_type'($urandom_range(0, 1)), 6'($urandom), 6'($urandom),
                         3'($urandom));
         else
            send_cell_op(OP_NONE, 6'($urandom), 6'($urandom), 3'($urandom));
      end
   endtask

   // Result stall bursts
   initial begin
      @(negedge clock);
      forever begin
         if (drain_stalls && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      life_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = life_rsp_t'(rsp_tdata[19:0]);
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.cell_age !== want.cell_age) begin
               $display("%0t: cell_age expected %0d actual %0d", $time, want.cell_age,
                        got.cell_age);
               error_count++;
            end
            if (got.all_dead !== want.all_dead) begin
               $display("%0t: all_dead expected %0d actual %0d", $time, want.all_dead,
                        got.all_dead);
               error_count++;
            end
            if (got.generation !== want.generation) begin
               $display("%0t: generation expected %0d actual %0d", $time, want.generation,
                        got.generation);
               error_count++;
            end
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("life_automaton_generation_step_unit_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      cell_ages = '{default: 3'd0};
      gen_count = '0;
      rows_reg  = 7'd64;
      cols_reg  = 7'd64;
      wrap_reg  = 1'b1;
      aging_reg = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_grid();
      test_aging_block();
      test_tiny_torus();
      test_random_colony(7'd8, 7'd8, 1'b1, 1'b0, 25);
      test_random_colony(7'd5, 7'd7, 1'b0, 1'b1, 25);
      test_random_colony(7'd1, 7'd4, 1'b1, 1'b1, 12);
      test_random_colony(7'd64, 7'd64, 1'b0, 1'b0, 8);
      test_random_colony(7'd2, 7'd1, 1'b0, 1'b1, 12);
      send_gaps    = 1'b0;
      drain_stalls = 1'b0;
      test_random_colony(7'd127, 7'd3, 1'b1, 1'b0, 15);
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("life_automaton_generation_step_unit_tb: clean");
      end else begin
         $display("life_automaton_generation_step_unit_tb: errors");
      end
      $finish;
   end

endmodule
